@@ design/gdd_pkg.sv @@
package gdd_pkg;

  // Reciprocal of 100 scaled by 2^20 and of 400 scaled by 2^22 (same integer).
  // Exact floor quotients for every 14-bit year.
  localparam logic [13:0] RECIP_C = 14'd10486;
  localparam int SHIFT_100 = 20;
  localparam int SHIFT_400 = 22;

  // Largest magnitude the 23-bit result carries
  localparam logic signed [23:0] DIFF_MAX = 24'sd4194303;

  // Per-date result handed from a date unit to the top level
  typedef struct packed {
    logic [22:0] ordinal;
    logic        ok;
  } date_res_t;

  // Length of a month; 0 for a code that is no month
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in a common year before the first of a month
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

@@ design/gdd_date_unit.sv @@
module gdd_date_unit (
  input  logic                clk,
  input  logic                en,
  input  logic [4:0]          day,
  input  logic [3:0]          month,
  input  logic [13:0]         year,
  output gdd_pkg::date_res_t  res
);
  import gdd_pkg::*;

  // Stage 1: reciprocal product for the century quotients, table lookup
  logic [27:0] prod;
  logic [27:0] prod_r;
  logic [13:0] y1_r;
  logic [4:0]  d1_r;
  logic [3:0]  m1_r;
  logic [8:0]  dbm1_r;

  assign prod = 28'(year) * 28'(RECIP_C);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod;
      y1_r   <= year;
      d1_r   <= day;
      m1_r   <= month;
      dbm1_r <= days_before(month);
    end
  end

  // Stage 2: leap rule, range check, year part of the ordinal
  logic [7:0]  f100;
  logic [5:0]  f400;
  logic        z100;
  logic        z400;
  logic        leap;
  logic [12:0] q4;
  logic [7:0]  c100;
  logic [5:0]  c400;
  logic [4:0]  len;
  logic        ok;
  logic [22:0] base;

  assign f100 = prod_r[SHIFT_100 +: 8];
  assign f400 = prod_r[SHIFT_400 +: 6];
  assign z100 = (15'(f100) * 15'd100) == {1'b0, y1_r};
  assign z400 = (15'(f400) * 15'd400) == {1'b0, y1_r};
  assign leap = ((y1_r[1:0] == 2'b00) && !z100) || z400;
  // ceil(y/4), ceil(y/100), ceil(y/400)
  assign q4   = 13'((15'(y1_r) + 15'd3) >> 2);
  assign c100 = f100 + 8'(!z100);
  assign c400 = f400 + 6'(!z400);
  assign len  = month_len(m1_r, leap);
  assign ok   = (m1_r >= 4'd1) && (m1_r <= 4'd12) && (d1_r >= 5'd1) && (d1_r <= len);
  assign base = 23'(y1_r) * 23'd365 + 23'(q4) - 23'(c100) + 23'(c400);

  logic [22:0] base_r;
  logic        ok_r;
  logic [4:0]  d2_r;
  logic [8:0]  dbm2_r;
  logic        adj_r;

  always_ff @(posedge clk) begin
    if (en) begin
      base_r <= base;
      ok_r   <= ok;
      d2_r   <= d1_r;
      dbm2_r <= dbm1_r;
      adj_r  <= leap && (m1_r > 4'd2);
    end
  end

  // Stage 3: add month offset, leap day and day of month
  date_res_t res_r;

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.ordinal <= base_r + 23'(dbm2_r) + 23'(adj_r) + 23'(d2_r);
      res_r.ok      <= ok_r;
    end
  end

  assign res = res_r;

endmodule

@@ design/gregorian_day_difference.sv @@
// Channel | Dir | Beat contents
// in_     | in  | two dates, end-day flag in tuser
// out_    | out | signed day difference, invalid flag in tuser
//
// The pipe has three date stages (reciprocal multiply, leap and range
// check, ordinal sum) and one difference/saturate stage.
// One beat is taken per cycle when the output side keeps up.
// Reset clears all stage valid bits; data registers are not reset.
// A stall at the output holds every stage; in_tready drops with it.
module gregorian_day_difference (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // first_day[4:0], first_month[8:5], first_year[22:9],
  // second_day[27:23], second_month[31:28], second_year[45:32], zero pad
  input  logic [47:0] in_tdata,
  // count_end_day[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // day_difference[22:0] (signed), zero pad
  output logic [23:0] out_tdata,
  // date_invalid[0]
  output logic        out_tuser
);
  import gdd_pkg::*;

  logic en;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  // Per-date pipelines
  date_res_t res_a;
  date_res_t res_b;

  gdd_date_unit u_first (
    .clk   (clk),
    .en    (en),
    .day   (in_tdata[4:0]),
    .month (in_tdata[8:5]),
    .year  (in_tdata[22:9]),
    .res   (res_a)
  );

  gdd_date_unit u_second (
    .clk   (clk),
    .en    (en),
    .day   (in_tdata[27:23]),
    .month (in_tdata[31:28]),
    .year  (in_tdata[45:32]),
    .res   (res_b)
  );

  // Valid bits and end-day flag ride alongside the date stages
  logic [2:0] vld_r;
  logic [2:0] ce_r;
  logic       out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[1:0], in_tvalid};
      out_vld_r <= vld_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ce_r <= {ce_r[1:0], in_tuser};
    end
  end

  // Difference, end-day adjust, saturation
  logic signed [23:0] diff_raw;
  logic signed [23:0] diff_adj;
  logic signed [23:0] diff_sat;
  logic               bad;

  assign diff_raw = signed'({1'b0, res_b.ordinal}) - signed'({1'b0, res_a.ordinal});
  assign bad      = !(res_a.ok && res_b.ok);

  always_comb begin
    diff_adj = diff_raw;
    if (ce_r[2]) begin
      diff_adj = (diff_raw < 0) ? diff_raw - 24'sd1 : diff_raw + 24'sd1;
    end
    diff_sat = diff_adj;
    if (diff_adj > DIFF_MAX) begin
      diff_sat = DIFF_MAX;
    end else if (diff_adj < -DIFF_MAX) begin
      diff_sat = -DIFF_MAX;
    end
    if (bad) begin
      diff_sat = '0;
    end
  end

  logic [22:0] out_diff_r;
  logic        out_bad_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_diff_r <= diff_sat[22:0];
      out_bad_r  <= bad;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_diff_r};
  assign out_tuser  = out_bad_r;

`ifndef SYNTHESIS
  // Invalid dates give a zero difference
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 24'd0))
    else $error("invalid beat carries nonzero difference");

  // Saturation never produces the most negative 23-bit code
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[22:0] != 23'h400000))
    else $error("difference outside saturation range");

  // A stalled output blocks the input side
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted while output stalled");

  // Output valid follows the last date stage when the pipe moves
  a_vld_follow: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> (out_tvalid == $past(vld_r[2])))
    else $error("output valid lost or invented");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_PAIRS = 1000;
  localparam int IDLE_LIMIT   = 5000;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AT      = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;
  localparam int DIFF_LIMIT   = 4194303;

  // One date pair plus the idle time the sender leaves after it
  typedef struct {
    logic [4:0]  d1;
    logic [3:0]  m1;
    logic [13:0] y1;
    logic [4:0]  d2;
    logic [3:0]  m2;
    logic [13:0] y2;
    logic        end_day;
    int          gap_after;
    bit          wait_empty;
  } date_pair_t;

  typedef struct {
    logic [22:0] diff;
    logic        invalid;
  } day_diff_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;

  date_pair_t pending_pairs[$];
  day_diff_t  expected_diffs[$];
  date_pair_t cur_pair;
  int         gap_left = 0;
  int         stall_left = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  int         results_seen = 0;
  int         mismatches = 0;
  int         idle_cycles = 0;
  int         cycle_cnt = 0;

  gregorian_day_difference DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Calendar arithmetic for the predictor
  // ---------------------------------------------------------------
  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    int unsigned len;
    case (m) inside
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:                     len = leap_year(y) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  // Days since 1 Jan of year 0 (day 1 of year 0 gives 1)
  function automatic int day_number(input int unsigned d, input int unsigned m,
                                    input int unsigned y);
    int n;
    n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    for (int unsigned i = 1; i < m; i++) n += month_length(i, y);
    return n + d;
  endfunction

  function automatic day_diff_t predict_difference(input date_pair_t p);
    day_diff_t r;
    int        diff;
    bit        ok1;
    bit        ok2;
    ok1 = (p.d1 >= 1) && (p.d1 <= month_length(p.m1, p.y1));
    ok2 = (p.d2 >= 1) && (p.d2 <= month_length(p.m2, p.y2));
    if (!ok1 || !ok2) begin
      r.diff    = '0;
      r.invalid = 1'b1;
      return r;
    end
    diff = day_number(p.d2, p.m2, p.y2) - day_number(p.d1, p.m1, p.y1);
    if (p.end_day) diff = (diff < 0) ? diff - 1 : diff + 1;
    if (diff > DIFF_LIMIT)  diff = DIFF_LIMIT;
    if (diff < -DIFF_LIMIT) diff = -DIFF_LIMIT;
    r.diff    = diff[22:0];
    r.invalid = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------
  task automatic add_pair(input int d1, input int m1, input int y1,
                          input int d2, input int m2, input int y2, input bit e);
    date_pair_t p;
    p.d1 = 5'(d1); p.m1 = 4'(m1); p.y1 = 14'(y1);
    p.d2 = 5'(d2); p.m2 = 4'(m2); p.y2 = 14'(y2);
    p.end_day    = e;
    p.gap_after  = $urandom_range(0, 2);
    p.wait_empty = 1'b0;
    pending_pairs.push_back(p);
  endtask

  // Mostly calendar dates; a share of raw field noise
  task automatic pick_date(output logic [4:0] d, output logic [3:0] m,
                           output logic [13:0] y);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 82) begin
      y = (r < 74) ? 14'($urandom_range(1, 9999)) : 14'($urandom_range(0, 16383));
      m = 4'($urandom_range(1, 12));
      d = 5'($urandom_range(1, month_length(m, y)));
    end else begin
      y = 14'($urandom_range(0, 16383));
      m = 4'($urandom_range(0, 15));
      d = 5'($urandom_range(0, 31));
    end
  endtask

  function automatic int pick_gap(input bit busy_run);
    int unsigned r;
    if (busy_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic build_random();
    date_pair_t p;
    bit         busy_run;
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i % 100 == 0) busy_run = ($urandom_range(0, 3) == 0);
      pick_date(p.d1, p.m1, p.y1);
      pick_date(p.d2, p.m2, p.y2);
      // close dates in the same year exercise small differences
      if ($urandom_range(0, 9) < 3) begin
        p.y2 = p.y1;
        if ($urandom_range(0, 1) == 1) p.m2 = p.m1;
      end
      p.end_day    = 1'($urandom_range(0, 1));
      p.gap_after  = pick_gap(busy_run);
      p.wait_empty = (i == 0) || (i == RANDOM_PAIRS / 2);
      pending_pairs.push_back(p);
    end
  endtask

  // ---------------------------------------------------------------
  // Driver: presents queued pairs, predicts on each accepted beat
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    logic next_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left  = 0;
    end else begin
      next_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        expected_diffs.push_back(predict_difference(cur_pair));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_pairs.size() > 0 &&
                     !(pending_pairs[0].wait_empty && expected_diffs.size() > 0)) begin
          cur_pair   = pending_pairs.pop_front();
          gap_left   = cur_pair.gap_after;
          next_valid = 1'b1;
          in_tdata <= {2'b00, cur_pair.y2, cur_pair.m2, cur_pair.d2,
                       cur_pair.y1, cur_pair.m1, cur_pair.d1};
          in_tuser <= cur_pair.end_day;
        end
      end
      in_tvalid <= next_valid;
    end
  end

  // ---------------------------------------------------------------
  // Long receiver hold-off once traffic is flowing
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen == HOLD_AT) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------
  // Monitor: random backpressure and result check
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    day_diff_t   exp_diff;
    logic        ready_next;
    int unsigned r;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (expected_diffs.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < MAX_REPORTS)
            $display("[%0t] unexpected result: diff=%0d invalid=%0b",
                     $realtime, $signed(out_tdata[22:0]), out_tuser);
        end else begin
          exp_diff = expected_diffs.pop_front();
          if (out_tdata[22:0] !== exp_diff.diff || out_tuser !== exp_diff.invalid) begin
            mismatches <= mismatches + 1;
            if (mismatches < MAX_REPORTS)
              $display("[%0t] mismatch: diff exp=%0d got=%0d, invalid exp=%0b got=%0b",
                       $realtime, $signed(exp_diff.diff), $signed(out_tdata[22:0]),
                       exp_diff.invalid, out_tuser);
          end
        end
      end
      // one window in four (cycle count bits 8 and 9 both set) may run without stalls
      if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (cycle_cnt[8] && cycle_cnt[9]) begin
        ready_next = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        ready_next = 1'b1;
        if (r >= 97) stall_left = $urandom_range(15, 50);
        else if (r >= 70) stall_left = $urandom_range(1, 4);
        if (stall_left > 0) ready_next = 1'b0;
      end
      out_tready <= ready_next && (hold_left == 0);
    end
  end

  // ---------------------------------------------------------------
  // Watchdog: no beat on either side for too long
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------
  // Sequence: directed pairs, random pairs, drain, verdict
  // ---------------------------------------------------------------
  initial begin
    // equal dates, with and without the end day
    add_pair(1, 1, 2000, 1, 1, 2000, 0);
    add_pair(1, 1, 2000, 1, 1, 2000, 1);
    // full calendar span both ways
    add_pair(1, 1, 1, 31, 12, 9999, 0);
    add_pair(1, 1, 1, 31, 12, 9999, 1);
    add_pair(31, 12, 9999, 1, 1, 1, 1);
    // leap day rules: 400-year leap, century non-leap, plain leap, common year
    add_pair(29, 2, 2000, 1, 3, 2000, 0);
    add_pair(29, 2, 1900, 1, 3, 1900, 0);
    add_pair(29, 2, 2004, 28, 2, 2005, 1);
    add_pair(1, 1, 2001, 29, 2, 2001, 0);
    // bad day or month in either date
    add_pair(0, 5, 2020, 1, 5, 2020, 1);
    add_pair(1, 4, 2020, 31, 4, 2020, 0);
    add_pair(1, 0, 2020, 1, 1, 2020, 0);
    add_pair(1, 1, 2020, 1, 13, 2020, 1);
    add_pair(31, 15, 16383, 31, 15, 16383, 1);
    // year boundary, reversed order
    add_pair(31, 12, 2023, 1, 1, 2024, 0);
    add_pair(1, 1, 2024, 31, 12, 2023, 1);
    // year 0 is a leap year
    add_pair(29, 2, 0, 1, 1, 1, 0);
    add_pair(1, 1, 0, 1, 1, 10000, 1);
    // magnitude past the result range saturates, then a short span in the top year
    add_pair(1, 1, 1, 31, 12, 16383, 0);
    add_pair(31, 12, 16383, 1, 1, 0, 1);
    add_pair(1, 1, 16383, 31, 12, 16383, 1);
    build_random();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_pairs.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_diffs.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
